// ----- src/ufe_pkg.sv -----
// Shared types, constants and state codes for the union-find engine.
package ufe_pkg;

   localparam int NODES  = 16;
   localparam int NODE_W = 4;
   localparam int ADDR_W = $clog2(NODES);
   localparam int SIZE_W = $clog2(NODES + 1);

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [SIZE_W-1:0] size_type;

   localparam logic FUNC_UNION = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic     func;
      node_type node_a;
      node_type node_b;
   } req_type;

   typedef struct packed {
      logic     connected;
      node_type root_after;
   } rsp_type;

   // Parent table access from the sequencer
   typedef struct packed {
      node_type rd_addr;
      logic     wr_en;
      node_type wr_addr;
      node_type wr_data;
   } parent_port_type;

   // Set size table access from the sequencer
   typedef struct packed {
      node_type rd_addr;
      logic     wr_en;
      node_type wr_addr;
      size_type wr_data;
   } size_port_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND_CHK,
      ST_FIND_HALVE,
      ST_SIZE_A,
      ST_LINK,
      ST_DONE
   } state_type;

endpackage

// ----- src/ufe_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module ufe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/ufe_parent_store.sv -----
// Parent table: RAM plus per-entry valid bits; an unwritten entry points to itself.
module ufe_parent_store (
   input  logic                     clock,
   input  logic                     reset,
   input  ufe_pkg::parent_port_type port,
   output ufe_pkg::node_type        rd_data
);
   import ufe_pkg::*;

   logic [NODES-1:0] valid_ff;
   logic [NODES-1:0] valid_in;
   logic             rd_valid_ff;
   node_type         rd_addr_ff;
   node_type         ram_q;

   ufe_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (port.wr_en),
      .wr_addr (port.wr_addr[ADDR_W-1:0]),
      .wr_data (port.wr_data),
      .rd_addr (port.rd_addr[ADDR_W-1:0]),
      .rd_data (ram_q)
   );

   always_comb begin
      valid_in = valid_ff;
      if (port.wr_en) begin
         valid_in[port.wr_addr[ADDR_W-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[port.rd_addr[ADDR_W-1:0]];
      end
      rd_addr_ff <= port.rd_addr;
   end

   assign rd_data = rd_valid_ff ? ram_q : rd_addr_ff;

endmodule

// ----- src/ufe_size_store.sv -----
// Set size table: RAM plus per-entry valid bits; an unwritten entry reads as one.
module ufe_size_store (
   input  logic                   clock,
   input  logic                   reset,
   input  ufe_pkg::size_port_type port,
   output ufe_pkg::size_type      rd_data
);
   import ufe_pkg::*;

   logic [NODES-1:0] valid_ff;
   logic [NODES-1:0] valid_in;
   logic             rd_valid_ff;
   size_type         ram_q;

   ufe_ram #(
      .WIDTH (SIZE_W),
      .DEPTH (NODES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (port.wr_en),
      .wr_addr (port.wr_addr[ADDR_W-1:0]),
      .wr_data (port.wr_data),
      .rd_addr (port.rd_addr[ADDR_W-1:0]),
      .rd_data (ram_q)
   );

   always_comb begin
      valid_in = valid_ff;
      if (port.wr_en) begin
         valid_in[port.wr_addr[ADDR_W-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[port.rd_addr[ADDR_W-1:0]];
      end
   end

   assign rd_data = rd_valid_ff ? ram_q : SIZE_W'(1);

endmodule

// ----- src/union_find_engine_unit.sv -----
// Union-find engine: weighted union with path-halving root search, one item at a time.
// Each root walk alternates FIND_CHK with a halving write in FIND_HALVE until a root is found;
// a union of two sets adds SIZE_A and LINK. Next item is taken once the result is queued.
// Items do not overlap: the next transfer is taken only in ST_IDLE;
// the single parent-table read port sets the pace.
// Reset: synchronous; valid bits make every table read back its reset value at once, no sweep.
module union_find_engine_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ufe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ufe_pkg::rsp_type rsp_data
);
   import ufe_pkg::*;

   state_type       state_ff, state_in;
   logic            phase_b_ff, phase_b_in;
   logic            func_ff, func_in;
   node_type        node_b_ff, node_b_in;
   node_type        x_ff, x_in;
   node_type        ra_ff, ra_in;
   size_type        sa_ff, sa_in;
   logic            res_conn_ff, res_conn_in;
   node_type        res_root_ff, res_root_in;
   rsp_type         rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   parent_port_type pport;
   size_port_type   sport;
   node_type        prd;
   size_type        srd;
   size_type        size_sum;
   logic            in_range;

   ufe_parent_store u_parent (
      .clock   (clock),
      .reset   (reset),
      .port    (pport),
      .rd_data (prd)
   );

   ufe_size_store u_size (
      .clock   (clock),
      .reset   (reset),
      .port    (sport),
      .rd_data (srd)
   );

   assign in_range = (int'(req_data.node_a) < NODES) && (int'(req_data.node_b) < NODES);
   assign size_sum = sa_ff + srd;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_b_ff  <= phase_b_in;
      func_ff     <= func_in;
      node_b_ff   <= node_b_in;
      x_ff        <= x_in;
      ra_ff       <= ra_in;
      sa_ff       <= sa_in;
      res_conn_ff <= res_conn_in;
      res_root_ff <= res_root_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      phase_b_in   = phase_b_ff;
      func_in      = func_ff;
      node_b_in    = node_b_ff;
      x_in         = x_ff;
      ra_in        = ra_ff;
      sa_in        = sa_ff;
      res_conn_in  = res_conn_ff;
      res_root_in  = res_root_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;

      pport         = '0;
      pport.rd_addr = x_ff;
      sport         = '0;
      sport.rd_addr = ra_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in   = req_data.func;
               node_b_in = req_data.node_b;
               if (!in_range) begin
                  res_conn_in = 1'b0;
                  res_root_in = req_data.node_a;
                  state_in    = ST_DONE;
               end else begin
                  x_in          = req_data.node_a;
                  pport.rd_addr = req_data.node_a;
                  phase_b_in    = 1'b0;
                  state_in      = ST_FIND_CHK;
               end
            end
         end
         ST_FIND_CHK: begin
            if (prd == x_ff) begin
               if (!phase_b_ff) begin
                  // root of node_a found, start the walk from node_b
                  ra_in         = x_ff;
                  x_in          = node_b_ff;
                  pport.rd_addr = node_b_ff;
                  phase_b_in    = 1'b1;
               end else if (func_ff == FUNC_UNION && ra_ff != x_ff) begin
                  sport.rd_addr = ra_ff;
                  state_in      = ST_SIZE_A;
               end else begin
                  res_conn_in = (ra_ff == x_ff);
                  res_root_in = ra_ff;
                  state_in    = ST_DONE;
               end
            end else begin
               pport.rd_addr = prd;
               state_in      = ST_FIND_HALVE;
            end
         end
         ST_FIND_HALVE: begin
            // prd is the grandparent: re-point x to it and continue from there
            pport.wr_en   = 1'b1;
            pport.wr_addr = x_ff;
            pport.wr_data = prd;
            x_in          = prd;
            pport.rd_addr = prd;
            state_in      = ST_FIND_CHK;
         end
         ST_SIZE_A: begin
            sa_in         = srd;
            sport.rd_addr = x_ff;
            state_in      = ST_LINK;
         end
         ST_LINK: begin
            // x_ff holds the root of node_b, srd its size
            pport.wr_en   = 1'b1;
            sport.wr_en   = 1'b1;
            sport.wr_data = size_sum;
            res_conn_in   = 1'b0;
            if (sa_ff < srd) begin
               pport.wr_addr = ra_ff;
               pport.wr_data = x_ff;
               sport.wr_addr = x_ff;
               res_root_in   = x_ff;
            end else begin
               pport.wr_addr = x_ff;
               pport.wr_data = ra_ff;
               sport.wr_addr = ra_ff;
               res_root_in   = ra_ff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.connected  = res_conn_ff;
               rsp_in.root_after = res_root_ff;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for the union-find engine: directed and random unions and queries.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ufe_pkg::*;

   localparam int RANDOM_ITEMS = 900;
   localparam int SETTLE_ITEMS = 150;    // tail of the run with no idling
   localparam int QUIET_LIMIT  = 3000;   // cycles with no transfer before giving up
   localparam int DRAIN_CYCLES = 60;

   // Tracks the disjoint sets and the replies the engine owes.
   class set_tracker;
      node_type leader_link[NODES];
      int unsigned members[NODES];
      rsp_type expected_replies[$];
      int failures;

      function new();
         for (int n = 0; n < NODES; n++) begin
            leader_link[n] = node_type'(n);
            members[n] = 1;
         end
         failures = 0;
      endfunction

      // Root search with path halving: each visited node jumps to its grandparent.
      function node_type find_leader(node_type x);
         node_type p;
         for (int step = 0; step < NODES; step++) begin
            p = leader_link[x];
            if (p == x) return x;
            leader_link[x] = leader_link[p];
            x = leader_link[x];
         end
         return x;
      endfunction

      function void note_request(req_type r);
         node_type ra, rb, joined;
         rsp_type reply;
         ra = find_leader(r.node_a);
         rb = find_leader(r.node_b);
         joined = ra;
         if (r.func == FUNC_UNION && ra != rb) begin
            if (members[ra] < members[rb]) begin
               leader_link[ra] = rb;
               members[rb] += members[ra];
               joined = rb;
            end else begin
               leader_link[rb] = ra;
               members[ra] += members[rb];
            end
         end
         reply.connected = (ra == rb);
         reply.root_after = joined;
         expected_replies.push_back(reply);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_replies.size() == 0) begin
            $error("unexpected result: connected %0d root_after %0d",
                   got.connected, got.root_after);
            failures++;
            return;
         end
         want = expected_replies.pop_front();
         if (got.connected !== want.connected) begin
            $error("connected: expected %0d, got %0d", want.connected, got.connected);
            failures++;
         end
         if (got.root_after !== want.root_after) begin
            $error("root_after: expected %0d, got %0d", want.root_after, got.root_after);
            failures++;
         end
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   bit         settle = 1'b0;
   set_tracker tracker = new();

   union_find_engine_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (req_valid && req_ready) tracker.note_request(req_data);
      if (rsp_valid && rsp_ready) tracker.check_response(rsp_data);
   end

   function automatic req_type make_req(logic f, int a, int b);
      req_type r;
      r.func = f;
      r.node_a = node_type'(a);
      r.node_b = node_type'(b);
      return r;
   endfunction

   // Unions are kept rare early on so the sets merge slowly and queries see many shapes.
   function automatic req_type random_item(int idx);
      req_type r;
      int union_odds;
      union_odds = (idx < 400) ? 11 : 2;
      r.func = ($urandom_range(0, union_odds) == 0) ? FUNC_UNION : FUNC_QUERY;
      r.node_a = node_type'($urandom_range(0, NODES - 1));
      r.node_b = ($urandom_range(0, 15) == 0) ? r.node_a
                                              : node_type'($urandom_range(0, NODES - 1));
      return r;
   endfunction

   task automatic send_item(req_type item);
      if (!settle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // Result side backpressure.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (!settle && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      req_type directed[$];
      directed = '{
         make_req(FUNC_QUERY, 0, 0),
         make_req(FUNC_QUERY, 0, 15),
         make_req(FUNC_UNION, 15, 15),     // same node: nothing to join
         make_req(FUNC_UNION, 0, 1),       // equal sizes, second root goes under first
         make_req(FUNC_UNION, 2, 3),
         make_req(FUNC_UNION, 3, 1),       // two pairs, equal sizes
         make_req(FUNC_UNION, 0, 2),       // already one set
         make_req(FUNC_UNION, 4, 5),
         make_req(FUNC_UNION, 6, 7),
         make_req(FUNC_UNION, 5, 7),
         make_req(FUNC_UNION, 8, 4),       // smaller set goes under larger
         make_req(FUNC_UNION, 3, 7),       // grows the tree a level
         make_req(FUNC_QUERY, 8, 1),       // long walk, halving rewrites the path
         make_req(FUNC_QUERY, 8, 1),
         make_req(FUNC_QUERY, 9, 8),
         make_req(FUNC_UNION, 15, 14),
         make_req(FUNC_UNION, 14, 13),
         make_req(FUNC_UNION, 10, 11),
         make_req(FUNC_UNION, 12, 9),
         make_req(FUNC_UNION, 9, 15),
         make_req(FUNC_QUERY, 13, 12),
         make_req(FUNC_UNION, 11, 12),
         make_req(FUNC_UNION, 10, 0),      // the last two sets merge
         make_req(FUNC_QUERY, 15, 0),
         make_req(FUNC_UNION, 15, 8)
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_item(directed[i]);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i >= RANDOM_ITEMS - SETTLE_ITEMS) settle = 1'b1;
         send_item(random_item(i));
      end
      req_valid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
